@@ sv/htc_pkg.sv @@
// shared types and constants for the humidity and temperature calibration pipeline
package htc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_TEMP_REF  = 3'd0,
    CFG_TEMP_OUT  = 3'd1,
    CFG_HUM_REF   = 3'd2,
    CFG_HUM_OUT   = 3'd3,
    CFG_USER_GAIN = 3'd4,
    CFG_USER_ICPT = 3'd5,
    CFG_TEMP_TRIM = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] raw_temperature;
    logic signed [15:0] raw_humidity;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic        [14:0] humidity;
    logic               hum_clamped;
    logic               temp_cal_invalid;
    logic               hum_cal_invalid;
  } out_t;

  // quotient bits kept by the dividers, larger quotients saturate
  localparam int unsigned QBITS = 18;
  // cycles from the edge that accepts a word to the edge that takes its result
  localparam int unsigned LATENCY = 25;
  localparam logic [14:0] HUM_MAX = 15'd25600;

endpackage

@@ sv/htc_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with saturation flag
module htc_div #(
  parameter int unsigned NW = 37,
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 18,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [QW-1:0] quo_o,
  output logic          big_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0] rem_q  [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic          big_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];

  // entry stage: overflow check against the full quotient range
  always_ff @(posedge clk_i) begin
    rem_q[0] <= CW'(num_i);
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    big_q[0] <= CW'(num_i) >= (CW'(den_i) << QW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q[0] <= '0;
    end else begin
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned SH = QW - 1 - k;
    logic [CW-1:0] trial;
    logic          fits;
    logic [QW-1:0] quo_d;

    always_comb begin
      trial     = CW'(den_q[k]) << SH;
      fits      = rem_q[k] >= trial;
      quo_d     = quo_q[k];
      quo_d[SH] = fits;
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= fits ? rem_q[k] - trial : rem_q[k];
      den_q[k+1] <= den_q[k];
      quo_q[k+1] <= quo_d;
      big_q[k+1] <= big_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k+1] <= '0;
      end else begin
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign quo_o  = quo_q[QW];
  assign big_o  = big_q[QW];
  assign side_o = side_q[QW];

endmodule

@@ sv/humidity_temp_calibration.sv @@
// two-point linear calibration of a temperature and humidity reading pair
// throughput: one word per cycle, busy_o stays low, the receiver cannot stall
// depth: five arithmetic stages, two 19-stage dividers in parallel, one output register
// reset clears the pipeline valid bits and loads the register defaults (gain unity)
module humidity_temp_calibration (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  htc_pkg::in_t     in_i,
  output logic             valid_o,
  output htc_pkg::out_t    out_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  localparam int unsigned QW = htc_pkg::QBITS;

  // ---------------------------------------------------------------
  // configuration registers, which the user must write only while the pipe is empty; the block does not check this
  // ---------------------------------------------------------------
  logic [19:0] temp_ref_q;
  logic [31:0] temp_out_q;
  logic [15:0] hum_ref_q;
  logic [31:0] hum_out_q;
  logic [19:0] gain_q;
  logic [15:0] icpt_q;
  logic [15:0] trim_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_ref_q <= '0;
      temp_out_q <= '0;
      hum_ref_q  <= '0;
      hum_out_q  <= '0;
      gain_q     <= 20'h10000;
      icpt_q     <= '0;
      trim_q     <= '0;
    end else if (cfg_valid_i) begin
      case (htc_pkg::cfg_idx_e'(cfg_index_i))
        htc_pkg::CFG_TEMP_REF:  temp_ref_q <= cfg_data_i[19:0];
        htc_pkg::CFG_TEMP_OUT:  temp_out_q <= cfg_data_i;
        htc_pkg::CFG_HUM_REF:   hum_ref_q  <= cfg_data_i[15:0];
        htc_pkg::CFG_HUM_OUT:   hum_out_q  <= cfg_data_i;
        htc_pkg::CFG_USER_GAIN: gain_q     <= cfg_data_i[19:0];
        htc_pkg::CFG_USER_ICPT: icpt_q     <= cfg_data_i[15:0];
        htc_pkg::CFG_TEMP_TRIM: trim_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // terms derived from the reference points (static while busy)
  // ---------------------------------------------------------------
  logic signed [10:0] t0r, dtr;
  logic signed [16:0] d_s, e_s;
  logic signed [8:0]  h0r, dhr;
  logic [15:0]        d_abs, e_abs;
  logic signed [15:0] t0o, h0o;
  logic signed [19:0] gain_s;
  logic signed [15:0] icpt_s, trim_s;

  always_comb begin
    t0r    = signed'({1'b0, temp_ref_q[9:0]});
    dtr    = signed'({1'b0, temp_ref_q[19:10]}) - t0r;
    t0o    = signed'(temp_out_q[15:0]);
    d_s    = 17'(signed'(temp_out_q[31:16])) - 17'(t0o);
    d_abs  = d_s[16] ? 16'(-d_s) : d_s[15:0];
    h0r    = signed'({1'b0, hum_ref_q[7:0]});
    dhr    = signed'({1'b0, hum_ref_q[15:8]}) - h0r;
    h0o    = signed'(hum_out_q[15:0]);
    e_s    = 17'(signed'(hum_out_q[31:16])) - 17'(h0o);
    e_abs  = e_s[16] ? 16'(-e_s) : e_s[15:0];
    gain_s = signed'(gain_q);
    icpt_s = signed'(icpt_q);
    trim_s = signed'(trim_q);
  end

  // ---------------------------------------------------------------
  // stage 1: offset the raw readings by the low-point outputs
  // ---------------------------------------------------------------
  logic               v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [16:0] x1_q, y1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= start_i & ~busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q <= 17'(in_i.raw_temperature) - 17'(t0o);
    y1_q <= 17'(in_i.raw_humidity) - 17'(h0o);
  end

  // ---------------------------------------------------------------
  // stage 2: partial products of the interpolation numerators
  // ---------------------------------------------------------------
  logic signed [27:0] tp1_q, tp2_q;
  logic signed [25:0] hp1_q, hp2_q;

  always_ff @(posedge clk_i) begin
    tp1_q <= 28'(t0r) * 28'(d_s);
    tp2_q <= 28'(dtr) * 28'(x1_q);
    hp1_q <= 26'(h0r) * 26'(e_s);
    hp2_q <= 26'(dhr) * 26'(y1_q);
  end

  // ---------------------------------------------------------------
  // stage 3: numerator sums (common scale factors dropped)
  // ---------------------------------------------------------------
  logic signed [28:0] tg_q;
  logic signed [26:0] hn_q;

  always_ff @(posedge clk_i) begin
    tg_q <= 29'(tp1_q) + 29'(tp2_q);
    hn_q <= 27'(hp1_q) + 27'(hp2_q);
  end

  // ---------------------------------------------------------------
  // stage 4: user gain; humidity magnitude with half-divisor rounding
  // ---------------------------------------------------------------
  logic signed [48:0] gg_q;
  logic [33:0]        hmag4_q;
  logic               hneg4_q;
  logic [26:0]        hn_abs;

  assign hn_abs = hn_q[26] ? 27'(-hn_q) : 27'(hn_q);

  always_ff @(posedge clk_i) begin
    gg_q    <= 49'(gain_s) * 49'(tg_q);
    hmag4_q <= {hn_abs, 7'b0} + 34'(e_abs[15:1]);
    hneg4_q <= hn_q[26] ^ e_s[16];
  end

  // ---------------------------------------------------------------
  // stage 5: temperature magnitude, round bias, drop the 2^11 scale
  // ---------------------------------------------------------------
  logic [48:0] gg_abs;
  logic [47:0] tsum;
  logic [36:0] tmag5_q;
  logic        tneg5_q;
  logic [33:0] hmag5_q;
  logic        hneg5_q;

  always_comb begin
    gg_abs = gg_q[48] ? 49'(-gg_q) : 49'(gg_q);
    tsum   = 48'(gg_abs) + 48'({d_abs, 10'b0});
  end

  always_ff @(posedge clk_i) begin
    tmag5_q <= tsum[47:11];
    tneg5_q <= gg_q[48] ^ d_s[16];
    hmag5_q <= hmag4_q;
    hneg5_q <= hneg4_q;
  end

  // ---------------------------------------------------------------
  // dividers, valid bit rides along the temperature one
  // ---------------------------------------------------------------
  logic [QW-1:0] tq, hq;
  logic          tbig, hbig;
  logic [1:0]    tside;
  logic          hneg;

  htc_div #(.NW(37), .DW(16), .QW(QW), .SW(2)) u_tdiv (
    .clk_i,
    .rst_ni,
    .num_i  (tmag5_q),
    .den_i  (d_abs),
    .side_i ({v5_q, tneg5_q}),
    .quo_o  (tq),
    .big_o  (tbig),
    .side_o (tside)
  );

  htc_div #(.NW(34), .DW(16), .QW(QW), .SW(1)) u_hdiv (
    .clk_i,
    .rst_ni,
    .num_i  (hmag5_q),
    .den_i  (e_abs),
    .side_i (hneg5_q),
    .quo_o  (hq),
    .big_o  (hbig),
    .side_o (hneg)
  );

  // ---------------------------------------------------------------
  // output stage: sign, offsets, saturation and humidity clamp
  // ---------------------------------------------------------------
  htc_pkg::out_t      res_d, res_q;
  logic               valid_q;
  logic signed [19:0] tsq;
  logic signed [20:0] tfin;
  logic               tneg;

  assign tneg = tside[0];

  always_comb begin
    tsq  = tneg ? -20'(signed'({1'b0, tq})) : 20'(signed'({1'b0, tq}));
    tfin = 21'(tsq) + 21'(icpt_s) + 21'(trim_s);
    res_d = '0;

    if (d_s == '0) begin
      res_d.temp_cal_invalid = 1'b1;
    end else if (tbig) begin
      res_d.temperature = tneg ? -16'sd32768 : 16'sd32767;
    end else if (tfin > 21'sd32767) begin
      res_d.temperature = 16'sd32767;
    end else if (tfin < -21'sd32768) begin
      res_d.temperature = -16'sd32768;
    end else begin
      res_d.temperature = tfin[15:0];
    end

    if (e_s == '0) begin
      res_d.hum_cal_invalid = 1'b1;
    end else if (hneg) begin
      // negative quotients clamp to zero unless they rounded to zero
      res_d.hum_clamped = hbig | (hq != '0);
    end else if (hbig || hq > QW'(htc_pkg::HUM_MAX)) begin
      res_d.humidity    = htc_pkg::HUM_MAX;
      res_d.hum_clamped = 1'b1;
    end else begin
      res_d.humidity = hq[14:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tside[1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign out_o   = res_q;

endmodule

@@ sv/htc_checker.sv @@
// port-level checker for the calibration block, bound to the top level
module htc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          valid_o,
  input htc_pkg::out_t out_o
);

  // every result strobe traces back to an accepted word a fixed latency earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, htc_pkg::LATENCY))
    else $error("result without matching start");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> out_o.humidity <= htc_pkg::HUM_MAX)
    else $error("humidity beyond full scale");

  a_clamp_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_o.hum_clamped |->
      out_o.humidity == 15'd0 || out_o.humidity == htc_pkg::HUM_MAX)
    else $error("clamp flag with interior humidity");

  a_hum_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_o.hum_cal_invalid |->
      out_o.humidity == 15'd0 && !out_o.hum_clamped)
    else $error("invalid humidity calibration not zeroed");

  a_temp_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_o.temp_cal_invalid |-> out_o.temperature == 16'sd0)
    else $error("invalid temperature calibration not zeroed");

endmodule

bind humidity_temp_calibration htc_checker u_htc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .valid_o (valid_o),
  .out_o   (out_o)
);

@@ tb/sv/tb_humidity_temp_calibration.sv @@
// testbench for the humidity and temperature calibration pipeline
`timescale 1ns / 1ps

// holds a copy of the calibration registers, the expected words and the checking
class calib_scoreboard;
  logic [19:0] temp_ref;
  logic [31:0] temp_out;
  logic [15:0] hum_ref;
  logic [31:0] hum_out;
  logic [19:0] gain;
  logic [15:0] icpt;
  logic [15:0] trim;
  htc_pkg::out_t expected_q[$];
  int unsigned   errors;

  function new();
    temp_ref = '0;
    temp_out = '0;
    hum_ref  = '0;
    hum_out  = '0;
    gain     = 20'd65536;
    icpt     = '0;
    trim     = '0;
    errors   = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      htc_pkg::CFG_TEMP_REF:  temp_ref = data[19:0];
      htc_pkg::CFG_TEMP_OUT:  temp_out = data;
      htc_pkg::CFG_HUM_REF:   hum_ref  = data[15:0];
      htc_pkg::CFG_HUM_OUT:   hum_out  = data;
      htc_pkg::CFG_USER_GAIN: gain     = data[19:0];
      htc_pkg::CFG_USER_ICPT: icpt     = data[15:0];
      htc_pkg::CFG_TEMP_TRIM: trim     = data[15:0];
      default: ;
    endcase
  endfunction

  // quotient rounded to nearest, ties away from zero
  function longint div_nearest(longint n, longint d);
    longint q;
    if (d < 0) begin
      d = -d;
      n = -n;
    end
    q = ((n < 0 ? -n : n) + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function htc_pkg::out_t calibrate(htc_pkg::in_t x);
    htc_pkg::out_t r;
    longint rt, rh, t0r, t1r, t0o, t1o, h0r, h1r, h0o, h1o, g, ic, tr;
    longint d, e, f, t, h;
    rt  = x.raw_temperature;
    rh  = x.raw_humidity;
    t0r = temp_ref[9:0];
    t1r = temp_ref[19:10];
    t0o = $signed(temp_out[15:0]);
    t1o = $signed(temp_out[31:16]);
    h0r = hum_ref[7:0];
    h1r = hum_ref[15:8];
    h0o = $signed(hum_out[15:0]);
    h1o = $signed(hum_out[31:16]);
    g   = $signed(gain);
    ic  = $signed(icpt);
    tr  = $signed(trim);
    r   = '0;
    d = t1o - t0o;
    if (d == 0) begin
      r.temp_cal_invalid = 1'b1;
    end else begin
      f = t0r * 8192 * d + (t1r - t0r) * (rt - t0o) * 8192;
      t = div_nearest(g * f, d * 64'sd16777216) + ic + tr;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      r.temperature = t[15:0];
    end
    e = h1o - h0o;
    if (e == 0) begin
      r.hum_cal_invalid = 1'b1;
    end else begin
      h = div_nearest(h0r * 128 * e + (h1r - h0r) * (rh - h0o) * 128, e);
      if (h < 0) begin
        h = 0;
        r.hum_clamped = 1'b1;
      end else if (h > 25600) begin
        h = 25600;
        r.hum_clamped = 1'b1;
      end
      r.humidity = h[14:0];
    end
    return r;
  endfunction

  function void note_input(htc_pkg::in_t x);
    expected_q.push_back(calibrate(x));
  endfunction

  function void check_result(htc_pkg::out_t got);
    htc_pkg::out_t exp_w;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
      errors++;
      return;
    end
    exp_w = expected_q.pop_front();
    if (got.temperature !== exp_w.temperature) begin
      $display("%0t: temperature expected %h actual %h", $realtime,
               exp_w.temperature, got.temperature);
      errors++;
    end
    if (got.humidity !== exp_w.humidity) begin
      $display("%0t: humidity expected %h actual %h", $realtime,
               exp_w.humidity, got.humidity);
      errors++;
    end
    if (got.hum_clamped !== exp_w.hum_clamped) begin
      $display("%0t: hum_clamped expected %b actual %b", $realtime,
               exp_w.hum_clamped, got.hum_clamped);
      errors++;
    end
    if (got.temp_cal_invalid !== exp_w.temp_cal_invalid) begin
      $display("%0t: temp_cal_invalid expected %b actual %b", $realtime,
               exp_w.temp_cal_invalid, got.temp_cal_invalid);
      errors++;
    end
    if (got.hum_cal_invalid !== exp_w.hum_cal_invalid) begin
      $display("%0t: hum_cal_invalid expected %b actual %b", $realtime,
               exp_w.hum_cal_invalid, got.hum_cal_invalid);
      errors++;
    end
  endfunction
endclass

module tb_humidity_temp_calibration;

  // index past the last register, writes there must be dropped
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 105;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start_i = 1'b0;
  logic          busy_o;
  htc_pkg::in_t  in_i = '0;
  logic          valid_o;
  htc_pkg::out_t out_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [2:0]    cfg_index_i = '0;
  logic [31:0]   cfg_data_i = '0;

  calib_scoreboard sb = new();
  int unsigned     stall_cnt = 0;

  always #5 clk_i = ~clk_i;

  humidity_temp_calibration u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .valid_o     (valid_o),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // every strobed result is taken at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(out_o);
  end

  // watchdog: any accepted word, config write or result resets the count
  always @(posedge clk_i) begin
    if (!rst_ni || valid_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // hold valid high across back-to-back writes, lowered by cfg_release
  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic cfg_release();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // write the whole register set plus a dropped write to the unused index
  task automatic cfg_all(logic [19:0] tref, logic [31:0] tout, logic [15:0] href,
                         logic [31:0] hout, logic [19:0] g, logic [15:0] ic,
                         logic [15:0] tr);
    cfg_write(htc_pkg::CFG_TEMP_REF, {12'($urandom), tref});
    cfg_write(htc_pkg::CFG_TEMP_OUT, tout);
    cfg_write(htc_pkg::CFG_HUM_REF, {16'($urandom), href});
    cfg_write(htc_pkg::CFG_HUM_OUT, hout);
    cfg_write(htc_pkg::CFG_USER_GAIN, {12'($urandom), g});
    cfg_write(htc_pkg::CFG_USER_ICPT, {16'($urandom), ic});
    cfg_write(htc_pkg::CFG_TEMP_TRIM, {16'($urandom), tr});
    cfg_write(CFG_UNUSED, $urandom);
    cfg_release();
  endtask

  // start stays high across consecutive words, dropped only for a gap or a drain
  task automatic send_word(logic [15:0] rt, logic [15:0] rh);
    start_i <= 1'b1;
    in_i    <= htc_pkg::in_t'{raw_temperature: rt, raw_humidity: rh};
    do @(posedge clk_i); while (busy_o);
    sb.note_input(htc_pkg::in_t'{raw_temperature: rt, raw_humidity: rh});
  endtask

  task automatic idle_gap(int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // let the pipeline empty before touching the registers
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
    repeat (htc_pkg::LATENCY + 4) @(posedge clk_i);
  endtask

  // raw reading near the span of two output points, or anywhere at all
  function automatic logic [15:0] pick_raw(logic [15:0] lo, logic [15:0] hi);
    int a, b, span;
    a = $signed(lo);
    b = $signed(hi);
    if (a > b) begin
      span = a;
      a = b;
      b = span;
    end
    if ($urandom_range(0, 2) == 0) return 16'($urandom);
    return 16'(a - 64 + int'($urandom_range(0, b - a + 128)));
  endfunction

  function automatic logic [31:0] pick_out_points();
    logic [15:0] lo;
    lo = 16'($urandom);
    case ($urandom_range(0, 7))
      0: return {lo, lo};                 // equal points, calibration invalid
      1, 2: return $urandom;
      default: return {lo + 16'($urandom_range(100, 4000)) *
                       ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF), lo};
    endcase
  endfunction

  initial begin
    logic [31:0] tout, hout;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: both output pairs equal, so both flags are raised
    send_word(16'h1234, 16'h8000);
    send_word(16'h7FFF, 16'h0000);
    drain();

    // plain points, humidity spans exactly 0..100 between its outputs
    cfg_all({10'd320, 10'd160}, {16'd900, 16'd100}, {8'd200, 8'd0},
            {16'd3000, 16'hFF38}, 20'd65536, 16'd0, 16'd0);
    send_word(16'd100, 16'hFF38);         // low points, humidity exactly 0
    send_word(16'd900, 16'd3000);         // high points, humidity exactly 100
    send_word(16'h8000, 16'h8000);
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'h0000, 16'hFFFF);
    send_word(16'hFFFF, 16'd1500);
    idle_gap(3);
    send_word(16'd500, 16'hFF37);         // just under, clamps to 0
    send_word(16'd501, 16'd3001);         // just over, clamps to 100
    drain();

    // reversed points at the extremes, largest gain and offsets: saturates high
    cfg_all({10'd0, 10'd1023}, {16'h8000, 16'h7FFF}, {8'd0, 8'd255},
            {16'h8000, 16'h7FFF}, 20'h7FFFF, 16'h7FFF, 16'h7FFF);
    send_word(16'h8000, 16'h8000);
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'h0000, 16'h0000);
    send_word(16'h5555, 16'hAAAA);
    drain();

    // most negative gain and offsets: saturates low
    cfg_all({10'd1023, 10'd0}, {16'h7FFF, 16'h8000}, {8'd255, 8'd255},
            {16'h0001, 16'h0000}, 20'h80000, 16'h8000, 16'h8000);
    send_word(16'h8000, 16'h8000);
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'hAAAA, 16'h5555);
    drain();

    // random register sets, each followed by a stream of words
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      tout = pick_out_points();
      hout = pick_out_points();
      cfg_all(20'($urandom), tout, 16'($urandom), hout,
              ($urandom_range(0, 1) ? 20'($urandom) : 20'($urandom_range(32768, 98304))),
              16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2048) - 1024),
              16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 512) - 256));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // no gaps at all in the closing phase
        if (p < RANDOM_PHASES - 1 && $urandom_range(0, 3) == 0)
          idle_gap($urandom_range(1, 16));
        send_word(pick_raw(tout[15:0], tout[31:16]), pick_raw(hout[15:0], hout[31:16]));
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ humidity_temp_calibration.f @@
sv/htc_pkg.sv
sv/htc_div.sv
sv/humidity_temp_calibration.sv
sv/htc_checker.sv
tb/sv/tb_humidity_temp_calibration.sv
